FILE: rtl/timer_slot_table_assert.svh
// ----------------------------------------------------------------------------
// timer_slot_table_assert
// Assertion macros used by the timer slot table RTL
// ----------------------------------------------------------------------------
`ifndef TIMER_SLOT_TABLE_ASSERT_SVH
`define TIMER_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define TST_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define TST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// Types and codes shared by the timer slot table controller and datapath
// ----------------------------------------------------------------------------
package tst_pkg;

  // command codes on the opcode port
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_QUERY    = 3'd1,
    OP_ADD_PER  = 3'd2,
    OP_ADD_ONE  = 3'd3,
    OP_CANCEL   = 3'd4
  } op_e;

  // result kinds on the kind port
  typedef enum logic [2:0] {
    KIND_FIRED       = 3'd0,
    KIND_TICK_DONE   = 3'd1,
    KIND_DELAY       = 3'd2,
    KIND_ACCEPTED    = 3'd3,
    KIND_REJECTED    = 3'd4,
    KIND_CANCEL_DONE = 3'd5
  } kind_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_ADD,
    ST_QCALC,
    ST_FINISH
  } state_e;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd1000;

  // controller to datapath
  typedef struct packed {
    logic  latch;
    logic  rd_scan;
    logic  rd_last;
    logic  wr_rearm;
    logic  wr_move;
    logic  wr_add;
    logic  add_periodic;
    logic  idx_inc;
    logic  min_upd;
    logic  qcalc;
    logic  emit;
    kind_e emit_kind;
    logic  emit_last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;
    logic due;
    logic periodic;
    logic task_hit;
    logic full;
  } ctrl_sts_t;

endpackage

FILE: rtl/tst_ctrl.sv
// ----------------------------------------------------------------------------
// tst_ctrl
// Sequencer for the timer slot table: walks the slots one read at a time
// ----------------------------------------------------------------------------
module tst_ctrl import tst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [2:0] opcode,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  state_e state, state_next;
  op_e    op, op_next;

  // state and operation registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_TICK;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.emit_kind = KIND_FIRED;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          case (opcode)
            OP_TICK, OP_QUERY, OP_CANCEL: begin
              op_next    = op_e'(opcode);
              state_next = ST_SCAN_RD;
            end
            OP_ADD_PER, OP_ADD_ONE: begin
              op_next    = op_e'(opcode);
              state_next = ST_ADD;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        if (sts.full) begin
          cmd.emit_kind = KIND_REJECTED;
        end else begin
          cmd.emit_kind    = KIND_ACCEPTED;
          cmd.wr_add       = 1'b1;
          cmd.add_periodic = (op == OP_ADD_PER);
        end
        state_next = ST_IDLE;
      end
      ST_SCAN_RD: begin
        if (sts.in_range) begin
          cmd.rd_scan = 1'b1;
          state_next  = ST_SCAN_EV;
        end else if (op == OP_QUERY) begin
          state_next = ST_QCALC;
        end else begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_kind = (op == OP_TICK) ? KIND_TICK_DONE : KIND_CANCEL_DONE;
          state_next    = ST_IDLE;
        end
      end
      ST_SCAN_EV: begin
        state_next = ST_SCAN_RD;
        case (op)
          OP_TICK: begin
            if (sts.due) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = KIND_FIRED;
              if (sts.periodic) begin
                cmd.wr_rearm = 1'b1;
                cmd.idx_inc  = 1'b1;
              end else begin
                state_next = ST_MOVE_RD;
              end
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
          OP_CANCEL: begin
            if (sts.task_hit) begin
              state_next = ST_MOVE_RD;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
          default: begin
            cmd.min_upd = 1'b1;
            cmd.idx_inc = 1'b1;
          end
        endcase
      end
      ST_MOVE_RD: begin
        cmd.rd_last = 1'b1;
        state_next  = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        cmd.wr_move = 1'b1;
        state_next  = ST_SCAN_RD;
      end
      ST_QCALC: begin
        cmd.qcalc  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.emit_kind = KIND_DELAY;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/tst_datapath.sv
// ----------------------------------------------------------------------------
// tst_datapath
// Slot memory, scan index, slot count, query arithmetic and result register
// ----------------------------------------------------------------------------
module tst_datapath import tst_pkg::*; #(
  parameter int MAX_TIMERS   = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output ctrl_sts_t   sts,
  input  logic [63:0] now_ms,
  input  logic [31:0] duration_ms,
  input  logic [7:0]  task_id,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        result_valid,
  output logic [2:0]  kind,
  output logic [7:0]  fired_task,
  output logic [15:0] delay_ms,
  output logic        last
);

  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int TW = TASK_ID_BITS;

  typedef struct packed {
    logic [63:0]   deadline;
    logic [31:0]   interval;
    logic          periodic;
    logic [TW-1:0] tid;
  } slot_t;

  slot_t mem [MAX_TIMERS];
  slot_t rd_data;

  logic [63:0]   lat_now;
  logic [31:0]   lat_dur;
  logic [TW-1:0] lat_task;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic [15:0]   idle_timeout;
  logic [63:0]   earliest;
  logic [63:0]   q_diff;
  logic          q_due;

  logic [15:0]   task_in_wide;
  logic [15:0]   task_rd_wide;
  logic [CW-1:0] last_pos;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_t         wr_data;
  logic [15:0]   delay_val;

  assign task_in_wide = 16'(task_id);
  assign task_rd_wide = 16'(rd_data.tid);
  assign last_pos     = count - CW'(1);

  // command operands
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_now  <= now_ms;
      lat_dur  <= duration_ms;
      lat_task <= task_in_wide[TW-1:0];
    end
  end

  // idle timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      idle_timeout <= cfg_wr_data;
    end
  end

  // scan index and slot count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      if (cmd.latch) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.wr_add) begin
        count <= count + CW'(1);
      end else if (cmd.wr_move) begin
        count <= last_pos;
      end
    end
  end

  // memory port selection
  always_comb begin
    rd_en   = cmd.rd_scan | cmd.rd_last;
    rd_addr = cmd.rd_last ? last_pos[IW-1:0] : idx[IW-1:0];
    wr_en   = cmd.wr_rearm | cmd.wr_move | cmd.wr_add;
    wr_addr = cmd.wr_add ? count[IW-1:0] : idx[IW-1:0];
    wr_data = rd_data;
    if (cmd.wr_rearm) begin
      wr_data.deadline = lat_now + 64'(rd_data.interval);
    end else if (cmd.wr_add) begin
      wr_data.deadline = lat_now + 64'(lat_dur);
      wr_data.interval = lat_dur;
      wr_data.periodic = cmd.add_periodic;
      wr_data.tid      = lat_task;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // status back to the controller
  assign sts.in_range = (idx < count);
  assign sts.due      = (lat_now >= rd_data.deadline);
  assign sts.periodic = rd_data.periodic;
  assign sts.task_hit = (rd_data.tid == lat_task);
  assign sts.full     = (count == CW'(MAX_TIMERS));

  // earliest deadline and its distance from now
  always_ff @(posedge clk) begin
    if (cmd.min_upd && ((idx == '0) || (rd_data.deadline < earliest))) begin
      earliest <= rd_data.deadline;
    end
    if (cmd.qcalc) begin
      q_due  <= (earliest <= lat_now);
      q_diff <= earliest - lat_now;
    end
  end

  // clamp of the reported delay
  always_comb begin
    if (count == '0) begin
      delay_val = idle_timeout;
    end else if (q_due) begin
      delay_val = '0;
    end else if (q_diff > 64'(idle_timeout)) begin
      delay_val = idle_timeout;
    end else begin
      delay_val = q_diff[15:0];
    end
  end

  // result register, one beat per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      kind       <= cmd.emit_kind;
      last       <= cmd.emit_last;
      fired_task <= (cmd.emit_kind == KIND_FIRED) ? task_rd_wide[7:0] : 8'd0;
      delay_ms   <= (cmd.emit_kind == KIND_DELAY) ? delay_val : 16'd0;
    end
  end

endmodule

FILE: rtl/timer_slot_table.sv
// ----------------------------------------------------------------------------
// timer_slot_table
// Timer slot table: add, cancel, tick and next-delay query over a slot memory
// ----------------------------------------------------------------------------
// Sequence: add checks for room and emits its beat from the ADD state; tick,
// query and cancel walk the slots with a read and an evaluate state per slot,
// plus a move read and a move write per removed slot; query ends via QCALC.
// Throughput: one command at a time; the next is taken at the final beat's edge.
// Results come at most one beat per cycle, strobed, and are never stalled.
// Synchronous reset empties the table and sets the idle timeout to 1000 ms.
// ----------------------------------------------------------------------------
module timer_slot_table import tst_pkg::*; #(
  parameter int MAX_TIMERS   = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [63:0] now_ms,
  input  logic [31:0] duration_ms,
  input  logic [7:0]  task_id,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        result_valid,
  output logic [2:0]  kind,
  output logic [7:0]  fired_task,
  output logic [15:0] delay_ms,
  output logic        last
);

  `include "timer_slot_table_assert.svh"

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  tst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // slot storage and arithmetic
  tst_datapath #(
    .MAX_TIMERS   (MAX_TIMERS),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .now_ms       (now_ms),
    .duration_ms  (duration_ms),
    .task_id      (task_id),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .kind         (kind),
    .fired_task   (fired_task),
    .delay_ms     (delay_ms),
    .last         (last)
  );

  // checks
  `TST_ASSERT_IMPLY(a_fired_not_last, result_valid && (kind == KIND_FIRED), !last, "fired beat marked last")
  `TST_ASSERT_IMPLY(a_last_idle, result_valid && last, !busy, "final beat while still busy")
  `TST_ASSERT_IMPLY(a_reject_full, result_valid && (kind == KIND_REJECTED), sts.full, "reject without a full table")
  `TST_ASSERT_NEXT(a_known_op_busy, start && !busy && (opcode <= OP_CANCEL), busy, "known command not started")

endmodule

FILE: tb/timer_table_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_table_monitor
// Watches command and result beats of the timer slot table, keeps its own
// copy of the slots and the idle timeout, predicts the result beats of each
// accepted command and checks every result beat against the oldest one due.
// ----------------------------------------------------------------------------
module timer_table_monitor import tst_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  opcode,
  input  logic [63:0] now_ms,
  input  logic [31:0] duration_ms,
  input  logic [7:0]  task_id,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        result_valid,
  input  logic [2:0]  kind,
  input  logic [7:0]  fired_task,
  input  logic [15:0] delay_ms,
  input  logic        last,
  output int          fails,
  output int          pending
);

  // one result beat as the table reports it
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tid;
    logic [15:0] delay;
    logic        fin;
  } timer_report_t;

  timer_report_t timer_reports_q[$];
  timer_report_t got_report;
  timer_report_t due_report;

  // shadow of the slot table
  logic [63:0] slot_deadline [SLOTS];
  logic [31:0] slot_interval [SLOTS];
  logic        slot_periodic [SLOTS];
  logic [7:0]  slot_tid      [SLOTS];
  int          armed_slots;
  logic [15:0] idle_timeout;
  int          err_count;

  function automatic void post_report(kind_e k, logic [7:0] t, logic [15:0] d, logic f);
    timer_report_t r;
    r.kind  = k;
    r.tid   = t;
    r.delay = d;
    r.fin   = f;
    timer_reports_q.push_back(r);
  endfunction

  // remove a slot by moving the last one into its place
  function automatic void drop_slot(int i);
    int j;
    j = armed_slots - 1;
    slot_deadline[i] = slot_deadline[j];
    slot_interval[i] = slot_interval[j];
    slot_periodic[i] = slot_periodic[j];
    slot_tid[i]      = slot_tid[j];
    armed_slots      = j;
  endfunction

  // apply one command to the shadow table and queue its result beats
  function automatic void predict_timer_cmd(op_e op, logic [63:0] now, logic [31:0] dur,
                                            logic [7:0] tid);
    int          i;
    logic [63:0] earliest;
    logic [63:0] wait_ms;
    case (op)
      OP_TICK: begin
        i = 0;
        while (i < armed_slots) begin
          if (now >= slot_deadline[i]) begin
            post_report(KIND_FIRED, slot_tid[i], 16'd0, 1'b0);
            // re-armed slot is not looked at again in this tick
            if (slot_periodic[i]) begin
              slot_deadline[i] = now + 64'(slot_interval[i]);
              i++;
            end else begin
              drop_slot(i);
            end
          end else begin
            i++;
          end
        end
        post_report(KIND_TICK_DONE, 8'd0, 16'd0, 1'b1);
      end
      OP_QUERY: begin
        if (armed_slots == 0) begin
          wait_ms = 64'(idle_timeout);
        end else begin
          earliest = slot_deadline[0];
          for (i = 1; i < armed_slots; i++)
            if (slot_deadline[i] < earliest) earliest = slot_deadline[i];
          if (earliest <= now) begin
            wait_ms = 64'd0;
          end else begin
            wait_ms = earliest - now;
            if (wait_ms > 64'(idle_timeout)) wait_ms = 64'(idle_timeout);
          end
        end
        post_report(KIND_DELAY, 8'd0, wait_ms[15:0], 1'b1);
      end
      OP_ADD_PER, OP_ADD_ONE: begin
        if (armed_slots >= SLOTS) begin
          post_report(KIND_REJECTED, 8'd0, 16'd0, 1'b1);
        end else begin
          slot_interval[armed_slots] = dur;
          slot_deadline[armed_slots] = now + 64'(dur);
          slot_periodic[armed_slots] = (op == OP_ADD_PER);
          slot_tid[armed_slots]      = tid;
          armed_slots++;
          post_report(KIND_ACCEPTED, 8'd0, 16'd0, 1'b1);
        end
      end
      OP_CANCEL: begin
        i = 0;
        while (i < armed_slots) begin
          if (slot_tid[i] == tid) drop_slot(i);
          else i++;
        end
        post_report(KIND_CANCEL_DONE, 8'd0, 16'd0, 1'b1);
      end
      // unknown codes leave the table alone and report nothing
      default: ;
    endcase
  endfunction

  // compare result beats first, then predict the newly accepted command
  always @(posedge clk) begin
    if (rst) begin
      timer_reports_q.delete();
      armed_slots  = 0;
      idle_timeout = IDLE_TIMEOUT_RST;
      err_count    = 0;
    end else begin
      if (cfg_wr_en) idle_timeout = cfg_wr_data;
      if (result_valid) begin
        got_report.kind  = kind_e'(kind);
        got_report.tid   = fired_task;
        got_report.delay = delay_ms;
        got_report.fin   = last;
        if (timer_reports_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected result beat kind=%0d task=%0d delay=%0d last=%0d",
                     $realtime, kind, fired_task, delay_ms, last);
        end else begin
          due_report = timer_reports_q.pop_front();
          if (got_report !== due_report) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: result mismatch exp kind=%0d task=%0d delay=%0d last=%0d",
                        " got kind=%0d task=%0d delay=%0d last=%0d"},
                       $realtime, due_report.kind, due_report.tid, due_report.delay,
                       due_report.fin, kind, fired_task, delay_ms, last);
          end
        end
      end
      if (start && !busy) predict_timer_cmd(op_e'(opcode), now_ms, duration_ms, task_id);
    end
    fails   <= err_count;
    pending <= timer_reports_q.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the timer slot table: a directed opening over the corner
// cases, then phases of random command sequences under several idle timeout
// settings, with bursty command issue. The monitor does all checking.
// ----------------------------------------------------------------------------
module tb import tst_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int PHASE_ITEMS    = 60;
  localparam int PHASES         = 6;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic [2:0]  opcode      = 3'd0;
  logic [63:0] now_ms      = 64'd0;
  logic [31:0] duration_ms = 32'd0;
  logic [7:0]  task_id     = 8'd0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  logic        busy;
  logic        result_valid;
  logic [2:0]  kind;
  logic [7:0]  fired_task;
  logic [15:0] delay_ms;
  logic        last;

  int          fails;
  int          pending;
  int          idle_cycles = 0;
  logic        driving     = 1'b0;
  int          burst_left  = 0;
  int          counted     = 0;
  logic [63:0] wall_ms     = 64'd0;

  always #2 clk = ~clk;

  timer_slot_table uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .now_ms       (now_ms),
    .duration_ms  (duration_ms),
    .task_id      (task_id),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .kind         (kind),
    .fired_task   (fired_task),
    .delay_ms     (delay_ms),
    .last         (last)
  );

  timer_table_monitor u_mon (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .now_ms       (now_ms),
    .duration_ms  (duration_ms),
    .task_id      (task_id),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .kind         (kind),
    .fired_task   (fired_task),
    .delay_ms     (delay_ms),
    .last         (last),
    .fails        (fails),
    .pending      (pending)
  );

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // issue one command beat; start stays high within a burst
  task automatic send_cmd(input logic [2:0] op, input logic [63:0] now,
                          input logic [31:0] dur, input logic [7:0] tid);
    opcode      <= op;
    now_ms      <= now;
    duration_ms <= dur;
    task_id     <= tid;
    start       <= 1'b1;
    driving     = 1'b1;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      start   <= 1'b0;
      driving = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
  endtask

  // hold off until every predicted result beat has come back
  task automatic drain(input int settle);
    if (driving) begin
      start   <= 1'b0;
      driving = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_idle_timeout(input logic [15:0] v);
    drain(SETTLE_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one random command; time mostly moves forward with random jumps
  task automatic random_cmd(input int add_bias);
    int          roll;
    logic [2:0]  op;
    logic [63:0] now;
    logic [31:0] dur;
    logic [7:0]  tid;
    roll = $urandom_range(0, 99);
    if (roll < 2)                op = 3'($urandom_range(5, 7));  // unknown codes
    else if (roll < 30)          op = OP_TICK;
    else if (roll < 46)          op = OP_QUERY;
    else if (roll < 62 + add_bias) op = $urandom_range(0, 1) ? OP_ADD_PER : OP_ADD_ONE;
    else if (roll < 74 + add_bias) op = OP_CANCEL;
    else                         op = OP_TICK;

    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      now = {$urandom, $urandom};
    end else begin
      wall_ms += $urandom_range(0, (roll < 20) ? 3000 : 200);
      now = wall_ms;
    end

    roll = $urandom_range(0, 99);
    if (roll < 65)      dur = $urandom_range(0, 1200);
    else if (roll < 82) dur = $urandom_range(0, 80000);
    else if (roll < 94) dur = $urandom;
    else                dur = 32'hFFFF_FFFF - $urandom_range(0, 15);

    tid = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));

    send_cmd(op, now, dur, tid);
    if (op <= OP_CANCEL) counted++;
    if ($urandom_range(0, 49) == 0) drain(0);
  endtask

  initial begin
    int          i;
    int          p;
    logic [15:0] timeout_val;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    burst_left = 3;

    // directed: empty table, wrap, unknown codes, full table, mass firing
    send_cmd(OP_QUERY, 64'd0, 32'd0, 8'd0);
    send_cmd(OP_TICK, 64'd0, 32'd0, 8'd0);
    send_cmd(OP_CANCEL, 64'd0, 32'd0, 8'd7);
    send_cmd(OP_ADD_PER, 64'd0, 32'd0, 8'd0);
    send_cmd(OP_ADD_ONE, '1, '1, 8'hFF);
    send_cmd(3'd5, 64'd0, 32'd0, 8'd0);
    send_cmd(3'd7, '1, '1, 8'hFF);
    send_cmd(OP_QUERY, 64'd0, 32'd0, 8'd0);
    for (i = 0; i < 14; i++)
      send_cmd(i[0] ? OP_ADD_ONE : OP_ADD_PER, 64'd100, 32'(i * 50), 8'(1 + i % 4));
    send_cmd(OP_ADD_ONE, 64'd100, 32'd5, 8'd9);
    send_cmd(OP_TICK, 64'd400, 32'd0, 8'd0);
    send_cmd(OP_CANCEL, 64'd400, 32'd0, 8'd2);
    send_cmd(OP_QUERY, 64'd400, 32'd0, 8'd0);
    send_cmd(OP_TICK, '1, 32'd0, 8'd0);

    // random phases, each under its own idle timeout
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       timeout_val = 16'd0;
        1:       timeout_val = 16'hFFFF;
        2:       timeout_val = 16'd1;
        5:       timeout_val = IDLE_TIMEOUT_RST;
        default: timeout_val = 16'($urandom_range(0, 65535));
      endcase
      set_idle_timeout(timeout_val);
      case (p % 3)
        0:       wall_ms = {$urandom, $urandom};
        1:       wall_ms = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40000);
        default: wall_ms = 64'($urandom_range(0, 5000));
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) random_cmd(p * 4);
    end

    drain(SETTLE_CYCLES);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tst_pkg.sv
rtl/tst_ctrl.sv
rtl/tst_datapath.sv
rtl/timer_slot_table.sv
tb/timer_table_monitor.sv
tb/tb.sv
